// ----- rtl/rgbcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB color correction package
// Shared types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package rgbcc_pkg;

	localparam int unsigned GAIN_FRAC_BITS = 16;
	localparam int unsigned NUM_CH         = 3;
	localparam int unsigned CFG_W          = 9;
	localparam int unsigned IDX_W          = 3;

	typedef logic [7:0]           chan_t;
	typedef logic signed [CFG_W-1:0] level_t;
	typedef logic [IDX_W-1:0]     reg_idx_t;

	localparam reg_idx_t REG_BRIGHTNESS = 3'd0;
	localparam reg_idx_t REG_CONTRAST   = 3'd1;
	localparam reg_idx_t REG_SATURATION = 3'd2;
	localparam reg_idx_t REG_RED_OFS    = 3'd3;
	localparam reg_idx_t REG_GREEN_OFS  = 3'd4;
	localparam reg_idx_t REG_BLUE_OFS   = 3'd5;

	typedef struct packed {
		logic [8:0] sum;
		logic       gray;
	} sat_ctl_t;

	// -256 is taken as -255
	function automatic level_t sat_level(level_t v);
		if (v == level_t'(9'h100)) begin
			return level_t'(9'h101);
		end
		return v;
	endfunction

	function automatic chan_t clamp_u8(logic signed [10:0] v);
		if (v < 11'sd0) begin
			return 8'd0;
		end else if (v > 11'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rgbcc_gain_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gain unit
// Recomputes contrast gain after a level write on a restoring divider, one
// quotient bit per cycle; saturation scale by reciprocal multiplication by
// 1/255; split, product fraction and scale are registered in turn.
// ----------------------------------------------------------------------------
module rgbcc_gain_div import rgbcc_pkg::*; #(
	parameter int unsigned GAIN_FRACTION_BITS = GAIN_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire reg_idx_t                          wr_index,
	input  wire level_t                            contrast_level,
	input  wire level_t                            saturation_level,
	output logic [GAIN_FRACTION_BITS+7:0]          contrast_gain,
	output logic signed [GAIN_FRACTION_BITS+3:0]   sat_scale,
	output logic                                   busy
);

	localparam int unsigned F        = GAIN_FRACTION_BITS;
	localparam int unsigned DW       = F + 18;
	localparam int unsigned CNT_W    = $clog2(DW + 1);
	localparam int unsigned CGW      = F + 8;
	localparam int unsigned SKW      = F + 4;
	localparam logic [31:0] RECIP_255 = 32'h80808081;
	localparam int unsigned RECIP_SH = 39;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	logic             c_pend_q;
	logic             s_pend_q;
	logic [1:0]       s_vld_q;
	logic             neg_q;
	logic [2:0]       s_hi_q;
	logic [7:0]       s_rem_q;
	logic [F-1:0]     s_lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    dvd_q;
	logic [16:0]      rem_q;
	logic [16:0]      den_q;
	logic [CGW-1:0]   gain_q;
	logic signed [SKW-1:0] scale_q;

	level_t           c_sat;
	logic signed [9:0] c_ext;
	logic [9:0]       c_plus;
	logic [9:0]       c_minus;
	logic [17:0]      c_num;
	logic [16:0]      c_den;
	logic [DW-1:0]    c_dvd;
	level_t           s_sat;
	logic signed [10:0] s_num;
	logic [10:0]      s_mag;
	logic [2:0]       s_hi;
	logic [7:0]       s_rem;
	logic [31:0]      s_x;
	logic [63:0]      s_prod;

	logic             load_c;
	logic             load_s;
	logic [17:0]      trial;
	logic             qbit;
	logic [16:0]      rem_next;
	logic [DW-1:0]    q_next;
	logic [SKW-1:0]   k_mag;

	assign c_sat   = sat_level(contrast_level);
	assign c_ext   = {c_sat[8], c_sat};
	assign c_plus  = c_ext + 10'sd255;
	assign c_minus = 10'sd259 - c_ext;
	assign c_num   = 18'(c_plus[8:0]) * 18'd259;
	assign c_den   = 17'(c_minus) * 17'd255;
	assign c_dvd   = (DW'(c_num) << F) + DW'(c_den[16:1]);

	assign s_sat   = sat_level(saturation_level);
	assign s_num   = {{2{s_sat[8]}}, s_sat} * 11'sd3 + 11'sd255;
	assign s_mag   = s_num[10] ? 11'(-s_num) : 11'(s_num);

	// split |255+3s| into whole multiples of 255 and a remainder
	always_comb begin
		if (s_mag >= 11'd1020) begin
			s_hi  = 3'd4;
			s_rem = 8'(s_mag - 11'd1020);
		end else if (s_mag >= 11'd765) begin
			s_hi  = 3'd3;
			s_rem = 8'(s_mag - 11'd765);
		end else if (s_mag >= 11'd510) begin
			s_hi  = 3'd2;
			s_rem = 8'(s_mag - 11'd510);
		end else if (s_mag >= 11'd255) begin
			s_hi  = 3'd1;
			s_rem = 8'(s_mag - 11'd255);
		end else begin
			s_hi  = 3'd0;
			s_rem = 8'(s_mag);
		end
	end

	assign s_x    = 32'({s_rem_q, {F{1'b0}}}) + 32'd127;
	assign s_prod = 64'(s_x) * 64'(RECIP_255);
	assign k_mag  = (SKW'(s_hi_q) << F) + SKW'(s_lo_q);

	assign load_c  = (state_q == ST_IDLE) && c_pend_q;
	assign load_s  = s_pend_q && (s_vld_q == 2'b00);

	assign trial    = {rem_q, dvd_q[DW-1]};
	assign qbit     = (trial >= {1'b0, den_q});
	assign rem_next = qbit ? 17'(trial - {1'b0, den_q}) : trial[16:0];
	assign q_next   = {dvd_q[DW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			c_pend_q <= 1'b0;
			s_pend_q <= 1'b0;
			s_vld_q  <= '0;
			cnt_q    <= '0;
			gain_q   <= CGW'(1) << F;
			scale_q  <= $signed(SKW'(1) << F);
		end else begin
			c_pend_q <= (c_pend_q && !load_c) || (wr_en && wr_index == REG_CONTRAST);
			s_pend_q <= (s_pend_q && !load_s) || (wr_en && wr_index == REG_SATURATION);
			s_vld_q  <= {s_vld_q[0], load_s};
			if (s_vld_q[1]) begin
				scale_q <= neg_q ? $signed(-k_mag) : $signed(k_mag);
			end
			case (state_q)
				ST_IDLE: begin
					if (load_c) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(DW);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
						gain_q  <= q_next[CGW-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			dvd_q <= c_dvd;
			rem_q <= '0;
			den_q <= c_den;
		end else if (state_q == ST_RUN) begin
			dvd_q <= q_next;
			rem_q <= rem_next;
		end
		if (load_s) begin
			neg_q   <= s_num[10];
			s_hi_q  <= s_hi;
			s_rem_q <= s_rem;
		end
		if (s_vld_q[0]) begin
			s_lo_q <= s_prod[RECIP_SH +: F];
		end
	end

	assign contrast_gain = gain_q;
	assign sat_scale     = scale_q;
	assign busy          = (state_q == ST_RUN) || c_pend_q || s_pend_q || (s_vld_q != 2'b00);

endmodule
`default_nettype wire

// ----- rtl/rgbcc_lane_pre.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Front lane
// Brightness offset and contrast gain for one channel, three stages.
// ----------------------------------------------------------------------------
module rgbcc_lane_pre import rgbcc_pkg::*; #(
	parameter int unsigned GAIN_FRACTION_BITS = GAIN_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire chan_t                        pix,
	input  wire level_t                       brightness,
	input  wire level_t                       contrast_level,
	input  wire logic [GAIN_FRACTION_BITS+7:0] contrast_gain,
	output chan_t                             ch_s3
);

	localparam int unsigned F  = GAIN_FRACTION_BITS;
	localparam int unsigned PW = F + 19;
	localparam logic signed [PW-1:0] MID = PW'(128) << F;

	chan_t                 b_s1;
	chan_t                 ch_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [9:0]     diff;
	logic signed [PW-1:0]  cv;
	logic signed [PW-1:0]  cs;
	chan_t                 c_res;

	assign diff = $signed({2'b00, b_s1}) - 10'sd128;
	assign cv   = prod_s2 + MID;
	assign cs   = cv >>> F;

	always_comb begin
		if (contrast_level == '0) begin
			c_res = ch_s2;
		end else if (cv < 0) begin
			c_res = 8'd0;
		end else if (cs > $signed(PW'(255))) begin
			c_res = 8'd255;
		end else begin
			c_res = cs[7:0];
		end
	end

	always_ff @(posedge clk) begin
		b_s1    <= clamp_u8($signed({3'b000, pix}) + {{2{brightness[8]}}, brightness});
		ch_s2   <= b_s1;
		prod_s2 <= PW'($signed({1'b0, contrast_gain})) * PW'(diff);
		ch_s3   <= c_res;
	end

endmodule
`default_nettype wire

// ----- rtl/rgbcc_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lane merge
// Max/min over the three lanes; midpoint sum and gray decision.
// ----------------------------------------------------------------------------
module rgbcc_merge import rgbcc_pkg::*; (
	input  wire logic   clk,
	input  wire chan_t  ch [NUM_CH],
	input  wire level_t saturation_level,
	output chan_t       ch_s4 [NUM_CH],
	output sat_ctl_t    ctl_s4
);

	chan_t              mx;
	chan_t              mn;
	level_t             s_sat;
	logic signed [10:0] spread;

	always_comb begin
		mx = ch[0];
		mn = ch[0];
		for (int i = 1; i < NUM_CH; i++) begin
			if (ch[i] > mx) begin
				mx = ch[i];
			end
			if (ch[i] < mn) begin
				mn = ch[i];
			end
		end
	end

	assign s_sat  = sat_level(saturation_level);
	assign spread = $signed({3'b000, mx}) - $signed({3'b000, mn})
		+ {{2{s_sat[8]}}, s_sat};

	always_ff @(posedge clk) begin
		ch_s4       <= ch;
		ctl_s4.sum  <= {1'b0, mx} + {1'b0, mn};
		ctl_s4.gray <= (spread <= 11'sd0);
	end

endmodule
`default_nettype wire

// ----- rtl/rgbcc_lane_post.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Back lane
// Saturation scaling around the midpoint and final channel offset.
// ----------------------------------------------------------------------------
module rgbcc_lane_post import rgbcc_pkg::*; #(
	parameter int unsigned GAIN_FRACTION_BITS = GAIN_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire chan_t                               ch,
	input  wire sat_ctl_t                            ctl,
	input  wire level_t                              saturation_level,
	input  wire logic signed [GAIN_FRACTION_BITS+3:0] sat_scale,
	input  wire level_t                              offset,
	output chan_t                                    out_s7
);

	localparam int unsigned F  = GAIN_FRACTION_BITS;
	localparam int unsigned PW = F + 15;
	localparam int unsigned VW = F + 16;

	logic signed [10:0]    d;
	logic signed [PW-1:0]  prod_s5;
	sat_ctl_t              ctl_s5;
	chan_t                 ch_s5;
	chan_t                 sat_s6;
	logic signed [VW-1:0]  sum_fx;
	logic signed [VW-1:0]  v;
	logic signed [VW-1:0]  vs;
	chan_t                 s_res;

	assign d      = $signed({2'b00, ch, 1'b0}) - $signed({2'b00, ctl.sum});
	assign sum_fx = $signed({{(VW-9-F){1'b0}}, ctl_s5.sum, {F{1'b0}}});
	assign v      = sum_fx + VW'(prod_s5);
	assign vs     = v >>> (F + 1);

	always_comb begin
		if (saturation_level == '0) begin
			s_res = ch_s5;
		end else if (ctl_s5.gray) begin
			s_res = ctl_s5.sum[8:1];
		end else if (v < 0) begin
			s_res = 8'd0;
		end else if (vs > $signed(VW'(255))) begin
			s_res = 8'd255;
		end else begin
			s_res = vs[7:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s5 <= PW'(sat_scale) * PW'(d);
		ctl_s5  <= ctl;
		ch_s5   <= ch;
		sat_s6  <= s_res;
		out_s7  <= clamp_u8($signed({3'b000, sat_s6}) + {{2{offset[8]}}, offset});
	end

endmodule
`default_nettype wire

// ----- rtl/rgb_color_correction_pipeline.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB color correction pipeline
// Brightness, contrast, saturation and per-channel offset on 8-bit RGB.
//
//   port group        direction  handshake
//   start/red,grn,blu in         taken when start && !busy
//   done/red,grn,blu  out        one-cycle strobe, no backpressure
//   wr_en/index/data  in         written on every edge with wr_en
//
// One pixel per clock while busy is low; it passes the front lanes, merge and
// back lanes to done. After a contrast write busy holds while the bit-serial
// divider runs, after a saturation write until the new scale is registered.
// Reset zeroes levels and valid bits, gains to 1.0; no data clearing pass.
// ----------------------------------------------------------------------------
module rgb_color_correction_pipeline import rgbcc_pkg::*; #(
	parameter int unsigned GAIN_FRACTION_BITS = GAIN_FRAC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [7:0]       red_in,
	input  wire logic [7:0]       green_in,
	input  wire logic [7:0]       blue_in,
	output logic                  done,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data
);

	localparam int unsigned F = GAIN_FRACTION_BITS;

	level_t bri_q;
	level_t con_q;
	level_t sat_q;
	level_t ofs_q [NUM_CH];

	logic [6:0]            vld_q;
	logic [F+7:0]          contrast_gain;
	logic signed [F+3:0]   sat_scale;

	chan_t    pix_in [NUM_CH];
	chan_t    pre_s3 [NUM_CH];
	chan_t    mrg_s4 [NUM_CH];
	sat_ctl_t ctl_s4;
	chan_t    post_s7 [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bri_q <= '0;
			con_q <= '0;
			sat_q <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				ofs_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_BRIGHTNESS: bri_q    <= level_t'(wr_data);
				REG_CONTRAST:   con_q    <= level_t'(wr_data);
				REG_SATURATION: sat_q    <= level_t'(wr_data);
				REG_RED_OFS:    ofs_q[0] <= level_t'(wr_data);
				REG_GREEN_OFS:  ofs_q[1] <= level_t'(wr_data);
				REG_BLUE_OFS:   ofs_q[2] <= level_t'(wr_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], start && !busy};
		end
	end

	rgbcc_gain_div #(
		.GAIN_FRACTION_BITS(F)
	) u_div (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (reg_idx_t'(wr_index)),
		.contrast_level   (con_q),
		.saturation_level (sat_q),
		.contrast_gain    (contrast_gain),
		.sat_scale        (sat_scale),
		.busy             (busy)
	);

	assign pix_in[0] = red_in;
	assign pix_in[1] = green_in;
	assign pix_in[2] = blue_in;

	for (genvar g = 0; g < NUM_CH; g++) begin : g_pre
		rgbcc_lane_pre #(
			.GAIN_FRACTION_BITS(F)
		) u_pre (
			.clk            (clk),
			.pix            (pix_in[g]),
			.brightness     (bri_q),
			.contrast_level (con_q),
			.contrast_gain  (contrast_gain),
			.ch_s3          (pre_s3[g])
		);
	end

	rgbcc_merge u_merge (
		.clk              (clk),
		.ch               (pre_s3),
		.saturation_level (sat_q),
		.ch_s4            (mrg_s4),
		.ctl_s4           (ctl_s4)
	);

	for (genvar g = 0; g < NUM_CH; g++) begin : g_post
		rgbcc_lane_post #(
			.GAIN_FRACTION_BITS(F)
		) u_post (
			.clk              (clk),
			.ch               (mrg_s4[g]),
			.ctl              (ctl_s4),
			.saturation_level (sat_q),
			.sat_scale        (sat_scale),
			.offset           (ofs_q[g]),
			.out_s7           (post_s7[g])
		);
	end

	assign done      = vld_q[6];
	assign red_out   = post_s7[0];
	assign green_out = post_s7[1];
	assign blue_out  = post_s7[2];

endmodule
`default_nettype wire
